@@ rtl/bitmap_heap_allocator_macros.svh @@
// Assertion macros for the heap allocator.
`ifndef BITMAP_HEAP_ALLOCATOR_MACROS_SVH
`define BITMAP_HEAP_ALLOCATOR_MACROS_SVH

// Checks an implication at every clock edge outside reset.
`define BHA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks an implication at every clock edge, reset included.
`define BHA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bha_pkg.sv @@
`timescale 1ns / 1ps

package bha_pkg;

    localparam int DEFAULT_HEAP_GRANULES = 1024;
    localparam int GRANULE_BYTES = 4;
    localparam int HEADER_BYTES = 4;
    localparam int USED_W = 13;
    localparam int REQ_W = 16;
    localparam int ADDR_W = 32;
    localparam int CHUNK_BITS = 8;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_ADDR = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RD,
        S_A_SCAN,
        S_F_RD,
        S_F_CHK,
        S_M_RD,
        S_M_WR,
        S_RESP
    } state_t;

endpackage

@@ rtl/bha_run_scan.sv @@
`timescale 1ns / 1ps

module bha_run_scan #(
    parameter int LEN_W = 11
) (
    input  logic [bha_pkg::CHUNK_BITS-1:0] busy,
    input  logic [LEN_W-1:0]               run_in,
    input  logic [LEN_W-1:0]               need,
    output logic                           found,
    output logic [2:0]                     pos,
    output logic [LEN_W-1:0]               run_out
);
    import bha_pkg::*;

    always_comb
    begin
        logic [LEN_W-1:0] run;
        run = run_in;
        found = 1'b0;
        pos = 3'd0;
        for (int i = 0; i < CHUNK_BITS; i++)
        begin
            if (!found)
            begin
                if (busy[i])
                begin
                    run = '0;
                end
                else
                begin
                    run = run + LEN_W'(1);
                    if (run == need)
                    begin
                        found = 1'b1;
                        pos = 3'(i);
                    end
                end
            end
        end
        run_out = run;
    end

endmodule

@@ rtl/bitmap_heap_allocator.sv @@
`timescale 1ns / 1ps
// Channel  Signals                                             Direction
// in       in_valid, in_ready, action, request_bytes,
//          release_address                                     into block
// out      out_valid, out_ready, status, granted_address,
//          used_bytes                                          out of block
// cfg      cfg_valid, cfg_ready, heap_base                     into block
//
// After reset a clearing pass empties both stores.
// Allocate scans the bitmap store 8 granules a cycle, then reads and rewrites
// each bitmap word touched by the run. Free reads the length store, checks
// the entry, then reads and rewrites each word touched. One request is in
// work at a time; a stalled result holds the engine until the output
// register is free.

module bitmap_heap_allocator #(
    parameter int HEAP_GRANULES = bha_pkg::DEFAULT_HEAP_GRANULES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        action,
    input  logic [bha_pkg::REQ_W-1:0]   request_bytes,
    input  logic [bha_pkg::ADDR_W-1:0]  release_address,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [bha_pkg::ADDR_W-1:0]  granted_address,
    output logic [bha_pkg::USED_W-1:0]  used_bytes,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bha_pkg::ADDR_W-1:0]  heap_base
);
    import bha_pkg::*;
    `include "bitmap_heap_allocator_macros.svh"

    localparam int GW = $clog2(HEAP_GRANULES);
    localparam int LW = $clog2(HEAP_GRANULES + 1);
    localparam int WORDS = (HEAP_GRANULES + 31) / 32;
    localparam int WW = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [31:0]            map_mem [WORDS];
    logic [LW+USED_W-1:0]   len_mem [HEAP_GRANULES];

    state_t                 state_reg, state_next;
    logic [GW-1:0]          clr_reg, clr_next;
    logic [ADDR_W-1:0]      base_reg, base_next;
    logic [USED_W-1:0]      used_reg, used_next;
    logic [LW-1:0]          need_reg, need_next;
    logic [USED_W-1:0]      total_reg, total_next;
    logic [WW-1:0]          word_reg, word_next;
    logic [1:0]             chunk_reg, chunk_next;
    logic [LW-1:0]          run_reg, run_next;
    logic [GW-1:0]          start_reg, start_next;
    logic [GW-1:0]          end_reg, end_next;
    logic [WW-1:0]          mw_reg, mw_next;
    logic                   set_reg, set_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic [ADDR_W-1:0]      res_addr_reg, res_addr_next;
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             status_reg, status_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [USED_W-1:0]      used_out_reg, used_out_next;

    logic                   map_we, map_re;
    logic [WW-1:0]          map_waddr, map_raddr;
    logic [31:0]            map_wdata;
    logic [31:0]            map_rdata_reg;
    logic                   len_we, len_re;
    logic [GW-1:0]          len_waddr, len_raddr;
    logic [LW+USED_W-1:0]   len_wdata;
    logic [LW+USED_W-1:0]   len_rdata_reg;

    logic [CHUNK_BITS-1:0]  chunk_busy;
    logic                   scan_found;
    logic [2:0]             scan_pos;
    logic [LW-1:0]          scan_run;
    logic [31:0]            word_mask;
    logic [16:0]            need_wide;
    logic [32:0]            free_lo, free_hi, free_addr, free_off;
    logic [31:0]            hit_granule;
    logic                   in_acc, out_load;

    assign in_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign granted_address = addr_reg;
    assign used_bytes = used_out_reg;
    assign out_load = (state_reg == S_RESP) && (!out_valid_reg || out_ready);

    always_comb
    begin
        for (int i = 0; i < CHUNK_BITS; i++)
        begin
            chunk_busy[i] = map_rdata_reg[32'(chunk_reg) * CHUNK_BITS + i]
                || ((32'(word_reg) * 32 + 32'(chunk_reg) * CHUNK_BITS + i)
                    >= 32'(HEAP_GRANULES));
        end
        for (int i = 0; i < 32; i++)
        begin
            word_mask[i] = ((32'(mw_reg) * 32 + i) >= 32'(start_reg))
                && ((32'(mw_reg) * 32 + i) <= 32'(end_reg));
        end
    end

    bha_run_scan #(
        .LEN_W (LW)
    ) u_scan (
        .busy    (chunk_busy),
        .run_in  (run_reg),
        .need    (need_reg),
        .found   (scan_found),
        .pos     (scan_pos),
        .run_out (scan_run)
    );

    assign need_wide = (17'(request_bytes) + 17'(HEADER_BYTES + GRANULE_BYTES - 1)) >> 2;
    assign free_addr = {1'b0, release_address};
    assign free_lo = {1'b0, base_reg} + 33'(HEADER_BYTES);
    assign free_hi = {1'b0, base_reg} + 33'(GRANULE_BYTES * HEAP_GRANULES);
    assign free_off = (free_addr - free_lo) >> 2;
    assign hit_granule = 32'(word_reg) * 32 + 32'(chunk_reg) * CHUNK_BITS + 32'(scan_pos);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (32'(clr_reg) == 32'(HEAP_GRANULES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (action == ACT_ALLOC)
                    begin
                        state_next = (32'(need_wide) > 32'(HEAP_GRANULES)) ? S_RESP : S_A_RD;
                    end
                    else
                    begin
                        state_next = (free_addr < free_lo || free_addr > free_hi)
                            ? S_RESP : S_F_RD;
                    end
                end
            end
            S_A_RD:
            begin
                state_next = S_A_SCAN;
            end
            S_A_SCAN:
            begin
                if (scan_found)
                begin
                    state_next = S_M_RD;
                end
                else if (chunk_reg == 2'd3 && 32'(word_reg) == 32'(WORDS - 1))
                begin
                    state_next = S_RESP;
                end
            end
            S_F_RD:
            begin
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                state_next = (len_rdata_reg[LW+USED_W-1:USED_W] == '0) ? S_RESP : S_M_RD;
            end
            S_M_RD:
            begin
                state_next = S_M_WR;
            end
            S_M_WR:
            begin
                state_next = (32'(mw_reg) == (32'(end_reg) >> 5)) ? S_RESP : S_M_RD;
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clr_next = clr_reg;
        base_next = (cfg_valid && cfg_ready) ? heap_base : base_reg;
        used_next = used_reg;
        need_next = need_reg;
        total_next = total_reg;
        word_next = word_reg;
        chunk_next = chunk_reg;
        run_next = run_reg;
        start_next = start_reg;
        end_next = end_reg;
        mw_next = mw_reg;
        set_next = set_reg;
        res_status_next = res_status_reg;
        res_addr_next = res_addr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next = status_reg;
        addr_next = addr_reg;
        used_out_next = used_out_reg;
        map_we = 1'b0;
        map_re = 1'b0;
        map_waddr = mw_reg;
        map_raddr = mw_reg;
        map_wdata = '0;
        len_we = 1'b0;
        len_re = 1'b0;
        len_waddr = start_reg;
        len_raddr = start_reg;
        len_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + GW'(1);
                len_we = 1'b1;
                len_waddr = clr_reg;
                if (32'(clr_reg) < 32'(WORDS))
                begin
                    map_we = 1'b1;
                    map_waddr = clr_reg[WW-1:0];
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    res_addr_next = '0;
                    if (action == ACT_ALLOC)
                    begin
                        res_status_next = ST_NO_SPACE;
                        need_next = LW'(need_wide);
                        total_next = request_bytes[USED_W-1:0] + USED_W'(HEADER_BYTES);
                        word_next = '0;
                        set_next = 1'b1;
                    end
                    else
                    begin
                        res_status_next = ST_BAD_ADDR;
                        start_next = free_off[GW-1:0];
                        set_next = 1'b0;
                    end
                end
            end
            S_A_RD:
            begin
                map_re = 1'b1;
                map_raddr = word_reg;
                chunk_next = '0;
                run_next = '0;
            end
            S_A_SCAN:
            begin
                run_next = scan_run;
                chunk_next = chunk_reg + 2'd1;
                if (scan_found)
                begin
                    end_next = GW'(hit_granule);
                    start_next = GW'(hit_granule + 32'd1 - 32'(need_reg));
                    mw_next = WW'((hit_granule + 32'd1 - 32'(need_reg)) >> 5);
                end
                else if (chunk_reg == 2'd3 && 32'(word_reg) != 32'(WORDS - 1))
                begin
                    word_next = word_reg + WW'(1);
                    map_re = 1'b1;
                    map_raddr = word_reg + WW'(1);
                end
            end
            S_F_RD:
            begin
                len_re = 1'b1;
            end
            S_F_CHK:
            begin
                total_next = len_rdata_reg[USED_W-1:0];
                end_next = GW'(32'(start_reg) + 32'(len_rdata_reg[LW+USED_W-1:USED_W]) - 32'd1);
                mw_next = WW'(32'(start_reg) >> 5);
            end
            S_M_RD:
            begin
                map_re = 1'b1;
            end
            S_M_WR:
            begin
                map_we = 1'b1;
                map_wdata = set_reg ? (map_rdata_reg | word_mask) : (map_rdata_reg & ~word_mask);
                mw_next = mw_reg + WW'(1);
                if (32'(mw_reg) == (32'(end_reg) >> 5))
                begin
                    len_we = 1'b1;
                    res_status_next = ST_OK;
                    if (set_reg)
                    begin
                        len_wdata = {need_reg, total_reg};
                        used_next = used_reg + total_reg;
                        res_addr_next = base_reg + 32'(start_reg) * 32'(GRANULE_BYTES)
                            + 32'(HEADER_BYTES);
                    end
                    else
                    begin
                        len_wdata = '0;
                        used_next = used_reg - total_reg;
                        res_addr_next = '0;
                    end
                end
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    status_next = res_status_reg;
                    addr_next = res_addr_reg;
                    used_out_next = used_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            base_reg <= '0;
            used_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            base_reg <= base_next;
            used_reg <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg <= need_next;
        total_reg <= total_next;
        word_reg <= word_next;
        chunk_reg <= chunk_next;
        run_reg <= run_next;
        start_reg <= start_next;
        end_reg <= end_next;
        mw_reg <= mw_next;
        set_reg <= set_next;
        res_status_reg <= res_status_next;
        res_addr_reg <= res_addr_next;
        status_reg <= status_next;
        addr_reg <= addr_next;
        used_out_reg <= used_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_re)
        begin
            map_rdata_reg <= map_mem[map_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        if (len_re)
        begin
            len_rdata_reg <= len_mem[len_raddr];
        end
    end

    `BHA_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready,
        "A new transaction was taken while the previous one was in work.")
    `BHA_ASSERT(a_fail_addr_zero, out_valid && status != ST_OK |-> granted_address == '0,
        "A failed transaction returned a nonzero address.")
    `BHA_ASSERT_ALWAYS(a_no_accept_in_clear, state_reg == S_CLEAR |-> !in_ready,
        "Input was ready during the clearing pass.")

endmodule
